// ===== hdl/assert_macros.svh =====
// Assertion macros for the buddy allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define BBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
package bba_pkg;
  localparam int TOTAL_LOG2_DEF = 30;
  localparam int MIN_LOG2_DEF   = 15;
  localparam int ADDR_W         = 30;
  localparam int REQ_W          = 31;
  localparam int LOG2_W         = 5;
  localparam int STAT_W         = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;

  typedef enum logic [1:0] {
    K_UNUSED = 2'd0,
    K_FREE   = 2'd1,
    K_ALLOC  = 2'd2,
    K_SPLIT  = 2'd3
  } node_kind_t;

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic [LOG2_W-1:0] block_log2;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } walk_res_t;
endpackage

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/bba_walk.sv =====
// Tree walk sequencer: sizes the request, walks the node store down and back up.
`include "assert_macros.svh"
module bba_walk import bba_pkg::*; #(
  parameter int TOTAL_LOG2 = TOTAL_LOG2_DEF,
  parameter int MIN_LOG2   = MIN_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  item,
  output logic      idle,
  input  logic      res_take,
  output walk_res_t res
);
  localparam int LEVELS     = (TOTAL_LOG2 > MIN_LOG2) ? TOTAL_LOG2 - MIN_LOG2 : 0;
  localparam int NODE_COUNT = (1 << (LEVELS + 1)) - 1;
  localparam int IDX_W      = LEVELS + 1;
  localparam int MAX_LOG2   = (TOTAL_LOG2 > MIN_LOG2) ? TOTAL_LOG2 : MIN_LOG2;
  localparam int ORD_W      = $clog2(MAX_LOG2 + 2);
  localparam int LEAF_ORD   = TOTAL_LOG2 - LEVELS;
  localparam int AW         = (TOTAL_LOG2 > ADDR_W) ? TOTAL_LOG2 : ADDR_W;
  localparam int REC_W      = 2 + ORD_W;

  typedef struct packed {
    node_kind_t       kind;
    logic [ORD_W-1:0] top;
  } rec_t;

  typedef enum logic [3:0] {
    S_CLR, S_CLR_ROOT, S_IDLE, S_SIZE, S_A_NODE, S_A_LEFT, S_A_RIGHT,
    S_A_SPL1, S_A_SPL2, S_F_NODE, S_UP_RD, S_UP_SIB, S_M_CL1, S_M_CL2, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ORD_W-1:0] ord_r, ord_nxt;
  logic [ORD_W-1:0] k_r, k_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic             op_r, op_nxt;
  logic [ORD_W-1:0] tl_r, tl_nxt;
  node_kind_t       ckind_r, ckind_nxt;
  logic [ORD_W-1:0] ctop_r, ctop_nxt;
  out_item_t        res_r, res_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rec_t             ram_wdata, rd;
  logic [REC_W-1:0] ram_rdata;

  logic [IDX_W-1:0] lch, rch, sib, par;
  logic             nonleaf, grow, lf, rf, go_right, fbit;
  logic [AW-1:0]    hbit, lowmask;
  logic [REQ_W-1:0] pw;
  logic [ORD_W-1:0] mx;

  bba_ram #(.WIDTH(REC_W), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd      = rec_t'(ram_rdata);
  assign lch     = IDX_W'({idx_r, 1'b1});
  assign rch     = lch + 1'b1;
  assign sib     = idx_r[0] ? idx_r + 1'b1 : idx_r - 1'b1;
  assign par     = (idx_r - 1'b1) >> 1;
  assign nonleaf = ord_r > ORD_W'(LEAF_ORD);
  assign hbit    = AW'(1) << (ord_r - 1'b1);
  assign lowmask = ~({AW{1'b1}} << ord_r);
  assign pw      = REQ_W'(1) << k_r;
  assign grow    = (k_r <= ORD_W'(TOTAL_LOG2)) && (k_r < ORD_W'(REQ_W)) && (pw < req_r);
  assign lf      = tl_r > k_r;
  assign rf      = rd.top > k_r;
  assign go_right = !lf || (rf && (rd.top < tl_r));
  assign fbit    = |(addr_r & hbit);
  assign mx      = (ctop_r > rd.top) ? ctop_r : rd.top;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    ord_nxt   = ord_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    addr_nxt  = addr_r;
    req_nxt   = req_r;
    op_nxt    = op_r;
    tl_nxt    = tl_r;
    ckind_nxt = ckind_r;
    ctop_nxt  = ctop_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '{kind: K_UNUSED, top: '0};
    ram_raddr = idx_r;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = S_CLR_ROOT;
        end
      end
      S_CLR_ROOT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{kind: K_FREE, top: ORD_W'(TOTAL_LOG2 + 1)};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt   = item.op;
          req_nxt  = item.req_bytes;
          addr_nxt = AW'(item.free_addr);
          k_nxt    = ORD_W'(MIN_LOG2);
          idx_nxt  = '0;
          ord_nxt  = ORD_W'(TOTAL_LOG2);
          base_nxt = '0;
          ram_raddr = '0;
          if (item.op == OP_ALLOC) begin
            state_nxt = S_SIZE;
          end else if ((AW'(item.free_addr) >> TOTAL_LOG2) != '0) begin
            res_nxt   = '{block_addr: '0, block_log2: '0, status: ST_BADADDR};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_NODE;
          end
        end
      end
      S_SIZE: begin
        ram_raddr = '0;
        if (grow) begin
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_A_NODE;
        end
      end
      S_A_NODE: begin
        if (idx_r == '0 && rd.top <= k_r) begin
          res_nxt   = '{block_addr: '0, block_log2: '0, status: ST_NOSPACE};
          state_nxt = S_DONE;
        end else if (rd.kind == K_SPLIT && nonleaf) begin
          ram_raddr = lch;
          state_nxt = S_A_LEFT;
        end else if (rd.kind == K_FREE) begin
          ram_we = 1'b1;
          if (ord_r > k_r && nonleaf) begin
            ram_wdata = '{kind: K_SPLIT, top: rd.top};
            state_nxt = S_A_SPL1;
          end else begin
            ram_wdata = '{kind: K_ALLOC, top: '0};
            ckind_nxt = K_ALLOC;
            ctop_nxt  = '0;
            res_nxt   = '{block_addr: base_r[ADDR_W-1:0], block_log2: LOG2_W'(ord_r),
                          status: ST_OK};
            state_nxt = (idx_r == '0) ? S_DONE : S_UP_RD;
          end
        end else begin
          res_nxt   = '{block_addr: '0, block_log2: '0, status: ST_NOSPACE};
          state_nxt = S_DONE;
        end
      end
      S_A_LEFT: begin
        tl_nxt    = rd.top;
        ram_raddr = rch;
        state_nxt = S_A_RIGHT;
      end
      S_A_RIGHT: begin
        idx_nxt   = go_right ? rch : lch;
        ram_raddr = go_right ? rch : lch;
        base_nxt  = go_right ? (base_r | hbit) : base_r;
        ord_nxt   = ord_r - 1'b1;
        state_nxt = S_A_NODE;
      end
      S_A_SPL1: begin
        ram_we    = 1'b1;
        ram_waddr = lch;
        ram_wdata = '{kind: K_FREE, top: ord_r};
        state_nxt = S_A_SPL2;
      end
      S_A_SPL2: begin
        ram_we    = 1'b1;
        ram_waddr = rch;
        ram_wdata = '{kind: K_FREE, top: ord_r};
        ram_raddr = lch;
        idx_nxt   = lch;
        ord_nxt   = ord_r - 1'b1;
        state_nxt = S_A_NODE;
      end
      S_F_NODE: begin
        if (rd.kind == K_SPLIT && nonleaf) begin
          idx_nxt   = fbit ? rch : lch;
          ram_raddr = fbit ? rch : lch;
          ord_nxt   = ord_r - 1'b1;
        end else if (rd.kind == K_ALLOC && (addr_r & lowmask) == '0) begin
          ram_we    = 1'b1;
          ram_wdata = '{kind: K_FREE, top: ord_r + 1'b1};
          ckind_nxt = K_FREE;
          ctop_nxt  = ord_r + 1'b1;
          res_nxt   = '{block_addr: '0, block_log2: LOG2_W'(ord_r), status: ST_OK};
          state_nxt = (idx_r == '0) ? S_DONE : S_UP_RD;
        end else begin
          res_nxt   = '{block_addr: '0, block_log2: '0, status: ST_BADADDR};
          state_nxt = S_DONE;
        end
      end
      S_UP_RD: begin
        ram_raddr = sib;
        state_nxt = S_UP_SIB;
      end
      S_UP_SIB: begin
        ram_we    = 1'b1;
        ram_waddr = par;
        if (op_r == OP_FREE && ckind_r == K_FREE && rd.kind == K_FREE) begin
          ram_wdata = '{kind: K_FREE, top: ctop_r + 1'b1};
          ctop_nxt  = ctop_r + 1'b1;
          state_nxt = S_M_CL1;
        end else begin
          ram_wdata = '{kind: K_SPLIT, top: mx};
          ckind_nxt = K_SPLIT;
          ctop_nxt  = mx;
          idx_nxt   = par;
          state_nxt = (par == '0) ? S_DONE : S_UP_RD;
        end
      end
      S_M_CL1: begin
        ram_we    = 1'b1;
        state_nxt = S_M_CL2;
      end
      S_M_CL2: begin
        ram_we    = 1'b1;
        ram_waddr = sib;
        idx_nxt   = par;
        state_nxt = (par == '0) ? S_DONE : S_UP_RD;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    idx_r   <= idx_nxt;
    ord_r   <= ord_nxt;
    k_r     <= k_nxt;
    base_r  <= base_nxt;
    addr_r  <= addr_nxt;
    req_r   <= req_nxt;
    op_r    <= op_nxt;
    tl_r    <= tl_nxt;
    ckind_r <= ckind_nxt;
    ctop_r  <= ctop_nxt;
    res_r   <= res_nxt;
  end

  assign idle      = state_r == S_IDLE;
  assign res.valid = state_r == S_DONE;
  assign res.item  = res_r;

  `BBA_ASSERT(a_res_hold, clk, rst_n, res.valid && !res_take |=> res.valid && $stable(res.item), "result dropped before transaction")
  `BBA_ASSERT(a_no_start_busy, clk, rst_n, start |-> idle, "transaction started while busy")
  `BBA_ASSERT_NR(a_rst_clear, clk, !rst_n |=> state_r == S_CLR, "reset did not start clearing pass")
endmodule

// ===== hdl/buddy_block_allocator.sv =====
// Top level of the binary buddy block allocator with valid/ready channels.
// Allocate sizes the request, descends the tree and updates the tops on the way back up;
//   free descends to the block and merges free buddies on the way back up.
// Throughput: one transaction at a time; the next is accepted from the cycle in which out_valid
//   rises, later while a result waits on out_ready.
// Reset: synchronous rst_n starts a clearing pass over all NODE_COUNT nodes (65535 at default).
module buddy_block_allocator import bba_pkg::*; #(
  parameter int TOTAL_LOG2 = TOTAL_LOG2_DEF,
  parameter int MIN_LOG2   = MIN_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic      walk_idle;
  logic      res_take;
  walk_res_t res;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  bba_walk #(.TOTAL_LOG2(TOTAL_LOG2), .MIN_LOG2(MIN_LOG2)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && in_ready),
    .item     (in_data),
    .idle     (walk_idle),
    .res_take (res_take),
    .res      (res)
  );

  assign in_ready = walk_idle;
  assign res_take = res.valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
